/* rtl/ased_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ased_pkg
// Shared widths, register codes, sequencer control word and microcode table
// for the accelerometer speech energy detector.
// ----------------------------------------------------------------------------
package ased_pkg;

    localparam int BLOCK_LEN_DEFAULT = 64;

    localparam int SAMPLE_W  = 13;
    localparam int ABSD_W    = 13;
    localparam int Q_W       = 26;
    localparam int ALPHA_W   = 16;
    localparam int RATIO_W   = 4;
    localparam int LEVEL_W   = 42;
    localparam int SUM_W     = 48;
    localparam int P_W       = Q_W + ALPHA_W;
    localparam int PROD_W    = LEVEL_W + ALPHA_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int FRAC_W    = 16;
    localparam int DIGIT_W   = 16;
    localparam int DIV_DIGITS = SUM_W / DIGIT_W;
    localparam int LOOP_W    = $clog2(DIV_DIGITS);
    localparam int PC_W      = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEECH_ALPHA     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_ALPHA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_RATIO  = 2'd2;

    localparam logic [ALPHA_W-1:0] SPEECH_ALPHA_RST     = 16'd1311;
    localparam logic [ALPHA_W-1:0] BACKGROUND_ALPHA_RST = 16'd66;
    localparam logic [RATIO_W-1:0] THRESHOLD_RATIO_RST  = 4'd2;

    // multiplier operand A
    localparam logic [1:0] MA_ABSD = 2'd0;
    localparam logic [1:0] MA_SA   = 2'd1;
    localparam logic [1:0] MA_BA   = 2'd2;
    // multiplier operand B
    localparam logic [1:0] MB_ABSD = 2'd0;
    localparam logic [1:0] MB_Q    = 2'd1;
    localparam logic [1:0] MB_FE   = 2'd2;
    localparam logic [1:0] MB_SE   = 2'd3;
    // product destination
    localparam logic [1:0] MD_NONE = 2'd0;
    localparam logic [1:0] MD_Q    = 2'd1;
    localparam logic [1:0] MD_P    = 2'd2;
    localparam logic [1:0] MD_R    = 2'd3;

    // datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_PREP     = 4'd1;
    localparam logic [3:0] OP_DIFF     = 4'd2;
    localparam logic [3:0] OP_UPD_FAST = 4'd3;
    localparam logic [3:0] OP_UPD_SLOW = 4'd4;
    localparam logic [3:0] OP_SUMS     = 4'd5;
    localparam logic [3:0] OP_DIV_INIT = 4'd6;
    localparam logic [3:0] OP_DIV_STEP = 4'd7;
    localparam logic [3:0] OP_EMIT     = 4'd8;
    localparam logic [3:0] OP_DIV_MUL  = 4'd9;

    // sequencer jump conditions
    localparam logic [2:0] J_NEXT  = 3'd0;
    localparam logic [2:0] J_WAIT  = 3'd1;
    localparam logic [2:0] J_FIRST = 3'd2;
    localparam logic [2:0] J_BLOCK = 3'd3;
    localparam logic [2:0] J_LOOP  = 3'd4;
    localparam logic [2:0] J_EMIT  = 3'd5;

    // program addresses
    localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] PC_PREP     = 4'd1;
    localparam logic [PC_W-1:0] PC_DIFF     = 4'd2;
    localparam logic [PC_W-1:0] PC_SQUARE   = 4'd3;
    localparam logic [PC_W-1:0] PC_FAST_P   = 4'd4;
    localparam logic [PC_W-1:0] PC_FAST_R   = 4'd5;
    localparam logic [PC_W-1:0] PC_FAST_UPD = 4'd6;
    localparam logic [PC_W-1:0] PC_SLOW_P   = 4'd7;
    localparam logic [PC_W-1:0] PC_SLOW_R   = 4'd8;
    localparam logic [PC_W-1:0] PC_SLOW_UPD = 4'd9;
    localparam logic [PC_W-1:0] PC_SUMS     = 4'd10;
    localparam logic [PC_W-1:0] PC_DIV_INIT = 4'd11;
    localparam logic [PC_W-1:0] PC_DIV_MUL  = 4'd12;
    localparam logic [PC_W-1:0] PC_DIV_STEP = 4'd13;
    localparam logic [PC_W-1:0] PC_EMIT     = 4'd14;

    typedef struct packed {
        logic            take;
        logic [1:0]      mul_a;
        logic [1:0]      mul_b;
        logic [1:0]      mul_dst;
        logic [3:0]      op;
        logic [2:0]      jmp;
        logic [PC_W-1:0] target;
    } ucode_t;

    function automatic ucode_t mk_word(
        input logic            take,
        input logic [1:0]      mul_a,
        input logic [1:0]      mul_b,
        input logic [1:0]      mul_dst,
        input logic [3:0]      op,
        input logic [2:0]      jmp,
        input logic [PC_W-1:0] target
    );
        ucode_t w;
        w.take    = take;
        w.mul_a   = mul_a;
        w.mul_b   = mul_b;
        w.mul_dst = mul_dst;
        w.op      = op;
        w.jmp     = jmp;
        w.target  = target;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            PC_IDLE:     w = mk_word(1'b1, MA_ABSD, MB_ABSD, MD_NONE, OP_NONE,     J_WAIT,  PC_IDLE);
            PC_PREP:     w = mk_word(1'b0, MA_ABSD, MB_ABSD, MD_NONE, OP_PREP,     J_FIRST, PC_IDLE);
            PC_DIFF:     w = mk_word(1'b0, MA_ABSD, MB_ABSD, MD_NONE, OP_DIFF,     J_NEXT,  PC_IDLE);
            PC_SQUARE:   w = mk_word(1'b0, MA_ABSD, MB_ABSD, MD_Q,    OP_NONE,     J_NEXT,  PC_IDLE);
            PC_FAST_P:   w = mk_word(1'b0, MA_SA,   MB_Q,    MD_P,    OP_NONE,     J_NEXT,  PC_IDLE);
            PC_FAST_R:   w = mk_word(1'b0, MA_SA,   MB_FE,   MD_R,    OP_NONE,     J_NEXT,  PC_IDLE);
            PC_FAST_UPD: w = mk_word(1'b0, MA_ABSD, MB_ABSD, MD_NONE, OP_UPD_FAST, J_NEXT,  PC_IDLE);
            PC_SLOW_P:   w = mk_word(1'b0, MA_BA,   MB_Q,    MD_P,    OP_NONE,     J_NEXT,  PC_IDLE);
            PC_SLOW_R:   w = mk_word(1'b0, MA_BA,   MB_SE,   MD_R,    OP_NONE,     J_NEXT,  PC_IDLE);
            PC_SLOW_UPD: w = mk_word(1'b0, MA_ABSD, MB_ABSD, MD_NONE, OP_UPD_SLOW, J_NEXT,  PC_IDLE);
            PC_SUMS:     w = mk_word(1'b0, MA_ABSD, MB_ABSD, MD_NONE, OP_SUMS,     J_BLOCK, PC_DIFF);
            PC_DIV_INIT: w = mk_word(1'b0, MA_ABSD, MB_ABSD, MD_NONE, OP_DIV_INIT, J_NEXT,  PC_IDLE);
            PC_DIV_MUL:  w = mk_word(1'b0, MA_ABSD, MB_ABSD, MD_NONE, OP_DIV_MUL,  J_NEXT,  PC_IDLE);
            PC_DIV_STEP: w = mk_word(1'b0, MA_ABSD, MB_ABSD, MD_NONE, OP_DIV_STEP, J_LOOP,  PC_DIV_MUL);
            PC_EMIT:     w = mk_word(1'b0, MA_ABSD, MB_ABSD, MD_NONE, OP_EMIT,     J_EMIT,  PC_IDLE);
            default:     w = mk_word(1'b0, MA_ABSD, MB_ABSD, MD_NONE, OP_NONE,     J_NEXT,  PC_IDLE);
        endcase
        return w;
    endfunction

    // 3-point median of signed samples
    function automatic logic signed [SAMPLE_W-1:0] med3(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic signed [SAMPLE_W-1:0] c
    );
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic signed [SAMPLE_W-1:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) begin
            m = lo;
        end else if (c >= hi) begin
            m = hi;
        end else begin
            m = c;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* rtl/accel_speech_energy_detector_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// accel_speech_energy_detector_top
// Median-filtered, differenced z-axis energy with fast/slow averages and a
// per-block speech flag, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// One z sample is taken per word; every BLOCK_LEN samples one result word is
// produced carrying the block means of the fast and slow energy averages and
// the speech flag. A sample takes one accept step plus ten sequencer steps
// through the single shared 16x42 multiplier before the next ready; the
// first sample of a block takes only the accept and prep steps. The last
// sample of a block also runs a second median pass, a divide by BLOCK_LEN
// for both means taken one 16-bit digit at a time over three digits, two
// steps a digit through a reciprocal multiply after a setup step, and an
// emit step, plus any wait for the result register to drain. The result
// register lets the next sample be taken while a result is still pending.
// Configuration writes must be done while the block is idle.
module accel_speech_energy_detector_top
    import ased_pkg::*;
#(
    parameter int BLOCK_LEN = BLOCK_LEN_DEFAULT
) (
    input  wire                       aclk,
    input  wire                       aresetn,

    input  wire                       cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]       cfg_index,
    input  wire [CFG_DATA_W-1:0]      cfg_wdata,

    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire signed [SAMPLE_W-1:0] s_z_sample,

    output logic                      m_valid,
    input  wire                       m_ready,
    output logic                      m_speech_detected,
    output logic [LEVEL_W-1:0]        m_speech_level,
    output logic [LEVEL_W-1:0]        m_background_level
);

    localparam int CNT_W  = $clog2(BLOCK_LEN);
    localparam int REM_W  = $clog2(BLOCK_LEN);
    // partial dividend of one digit step: remainder above the next digit
    localparam int DIVN_W = REM_W + DIGIT_W;
    localparam int RCP_SH = DIVN_W + REM_W;
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(BLOCK_LEN - 1);
    localparam logic [63:0]       RCP_WIDE = ((64'd1 << RCP_SH) + 64'(BLOCK_LEN) - 64'd1)
                                             / 64'(BLOCK_LEN);
    localparam logic [DIVN_W:0]   RECIP    = (DIVN_W + 1)'(RCP_WIDE);
    localparam logic [DIVN_W-1:0] DIVISOR  = DIVN_W'(BLOCK_LEN);
    localparam logic [LOOP_W-1:0] DIV_LAST = LOOP_W'(DIV_DIGITS - 1);
    localparam logic [ACC_W-1:0]  ROUND    = ACC_W'(1) << (FRAC_W - 1);

    // configuration
    logic [ALPHA_W-1:0] speech_alpha_reg;
    logic [ALPHA_W-1:0] background_alpha_reg;
    logic [RATIO_W-1:0] threshold_ratio_reg;

    // sequencer
    logic [PC_W-1:0]    pc_reg;
    logic [PC_W-1:0]    pc_next;
    ucode_t             cw;
    logic [CNT_W-1:0]   count_reg;
    logic               tail_reg;
    logic [LOOP_W-1:0]  loop_reg;

    // datapath
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] win0_reg;
    logic signed [SAMPLE_W-1:0] win1_reg;
    logic signed [SAMPLE_W-1:0] med_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic [ABSD_W-1:0]          absd_reg;
    logic [Q_W-1:0]             q_reg;
    logic [P_W-1:0]             p_reg;
    logic [PROD_W-1:0]          r_reg;
    logic [LEVEL_W-1:0]         fast_reg;
    logic [LEVEL_W-1:0]         slow_reg;
    logic [SUM_W-1:0]           fsum_reg;
    logic [SUM_W-1:0]           ssum_reg;
    logic [REM_W-1:0]           frem_reg;
    logic [REM_W-1:0]           srem_reg;
    logic [DIGIT_W-1:0]         fq_reg;
    logic [DIGIT_W-1:0]         sq_reg;
    logic                       out_valid_reg;

    logic                       accept;
    logic                       first;
    logic                       last;
    logic                       out_free;
    logic [ALPHA_W-1:0]         mul_a_val;
    logic [LEVEL_W-1:0]         mul_b_val;
    logic [PROD_W-1:0]          product;
    logic signed [SAMPLE_W:0]   diff;
    logic [SAMPLE_W:0]          diff_abs;
    logic [LEVEL_W-1:0]         ema_src;
    logic [ACC_W-1:0]           ema_acc;
    logic [LEVEL_W-1:0]         ema_next;
    logic [SUM_W:0]             fsum_add;
    logic [SUM_W:0]             ssum_add;
    logic [DIVN_W-1:0]          fdiv_t;
    logic [DIVN_W-1:0]          sdiv_t;
    logic [2*DIVN_W:0]          fdiv_prod;
    logic [2*DIVN_W:0]          sdiv_prod;
    logic [DIVN_W-1:0]          fdiv_back;
    logic [DIVN_W-1:0]          sdiv_back;
    logic [LEVEL_W+RATIO_W-1:0] bg_scaled;
    logic                       flag;

    assign cw       = ucode_rom(pc_reg);
    assign s_ready  = cw.take;
    assign accept   = s_valid && s_ready;
    assign first    = (count_reg == '0);
    assign last     = (count_reg == CNT_LAST);
    assign out_free = !out_valid_reg || m_ready;

    // shared multiplier
    always_comb begin
        unique case (cw.mul_a)
            MA_SA:   mul_a_val = speech_alpha_reg;
            MA_BA:   mul_a_val = background_alpha_reg;
            default: mul_a_val = ALPHA_W'(absd_reg);
        endcase
        unique case (cw.mul_b)
            MB_Q:    mul_b_val = LEVEL_W'(q_reg);
            MB_FE:   mul_b_val = fast_reg;
            MB_SE:   mul_b_val = slow_reg;
            default: mul_b_val = LEVEL_W'(absd_reg);
        endcase
    end
    assign product = PROD_W'(mul_a_val) * PROD_W'(mul_b_val);

    assign diff     = {med_reg[SAMPLE_W-1], med_reg} - {prev_reg[SAMPLE_W-1], prev_reg};
    assign diff_abs = diff[SAMPLE_W] ? (SAMPLE_W + 1)'(-diff) : diff;

    // e' = ((a*q + e) << 16) - a*e + half, then drop the fraction
    assign ema_src  = (cw.op == OP_UPD_SLOW) ? slow_reg : fast_reg;
    assign ema_acc  = (ACC_W'(p_reg) << FRAC_W) + (ACC_W'(ema_src) << FRAC_W)
                      + ROUND - ACC_W'(r_reg);
    assign ema_next = ema_acc[LEVEL_W+FRAC_W-1:FRAC_W];

    assign fsum_add = {1'b0, fsum_reg} + (SUM_W + 1)'(fast_reg);
    assign ssum_add = {1'b0, ssum_reg} + (SUM_W + 1)'(slow_reg);

    // long division by the block length, one 16-bit digit per pass; the
    // digit comes from a reciprocal multiply, exact for any partial dividend
    // below BLOCK_LEN << 16, and the remainder is taken back in the next step
    assign fdiv_t    = {frem_reg, fsum_reg[SUM_W-1 -: DIGIT_W]};
    assign sdiv_t    = {srem_reg, ssum_reg[SUM_W-1 -: DIGIT_W]};
    assign fdiv_prod = (2*DIVN_W + 1)'(fdiv_t) * (2*DIVN_W + 1)'(RECIP);
    assign sdiv_prod = (2*DIVN_W + 1)'(sdiv_t) * (2*DIVN_W + 1)'(RECIP);
    assign fdiv_back = DIVN_W'(fq_reg) * DIVISOR;
    assign sdiv_back = DIVN_W'(sq_reg) * DIVISOR;

    assign bg_scaled = (LEVEL_W + RATIO_W)'(threshold_ratio_reg)
                       * (LEVEL_W + RATIO_W)'(ssum_reg[LEVEL_W-1:0]);
    assign flag      = (LEVEL_W + RATIO_W)'(fsum_reg[LEVEL_W-1:0]) > bg_scaled;

    always_comb begin
        pc_next = pc_reg + 1'b1;
        unique case (cw.jmp)
            J_NEXT: begin
            end
            J_WAIT: begin
                if (!s_valid) pc_next = pc_reg;
            end
            J_FIRST: begin
                if (first) pc_next = cw.target;
            end
            J_BLOCK: begin
                if (!last) begin
                    pc_next = PC_IDLE;
                end else if (!tail_reg) begin
                    pc_next = cw.target;
                end
            end
            J_LOOP: begin
                if (loop_reg != DIV_LAST) pc_next = cw.target;
            end
            J_EMIT: begin
                pc_next = out_free ? cw.target : pc_reg;
            end
            default: pc_next = PC_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speech_alpha_reg     <= SPEECH_ALPHA_RST;
            background_alpha_reg <= BACKGROUND_ALPHA_RST;
            threshold_ratio_reg  <= THRESHOLD_RATIO_RST;
            pc_reg               <= PC_IDLE;
            count_reg            <= '0;
            tail_reg             <= 1'b0;
            loop_reg             <= '0;
            out_valid_reg        <= 1'b0;
            win0_reg             <= '0;
            win1_reg             <= '0;
            prev_reg             <= '0;
            fast_reg             <= '0;
            slow_reg             <= '0;
            fsum_reg             <= '0;
            ssum_reg             <= '0;
        end else begin
            pc_reg <= pc_next;

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_SPEECH_ALPHA:     speech_alpha_reg     <= cfg_wdata;
                    CFG_BACKGROUND_ALPHA: background_alpha_reg <= cfg_wdata;
                    CFG_THRESHOLD_RATIO:  threshold_ratio_reg  <= cfg_wdata[RATIO_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (cw.op == OP_EMIT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            unique case (cw.op)
                OP_PREP: begin
                    if (first) begin
                        win0_reg  <= x_reg;
                        win1_reg  <= x_reg;
                        count_reg <= count_reg + 1'b1;
                    end else begin
                        win0_reg <= win1_reg;
                        win1_reg <= x_reg;
                    end
                end
                OP_DIFF: begin
                    prev_reg <= med_reg;
                end
                OP_UPD_FAST: begin
                    fast_reg <= ema_next;
                end
                OP_UPD_SLOW: begin
                    slow_reg <= ema_next;
                end
                OP_SUMS: begin
                    fsum_reg <= fsum_add[SUM_W] ? '1 : fsum_add[SUM_W-1:0];
                    ssum_reg <= ssum_add[SUM_W] ? '1 : ssum_add[SUM_W-1:0];
                    if (!last) begin
                        count_reg <= count_reg + 1'b1;
                    end else if (!tail_reg) begin
                        tail_reg <= 1'b1;
                    end
                end
                OP_DIV_INIT: begin
                    loop_reg <= '0;
                end
                OP_DIV_STEP: begin
                    // quotient digits shift in from the bottom
                    fsum_reg <= {fsum_reg[SUM_W-DIGIT_W-1:0], fq_reg};
                    ssum_reg <= {ssum_reg[SUM_W-DIGIT_W-1:0], sq_reg};
                    loop_reg <= loop_reg + 1'b1;
                end
                OP_EMIT: begin
                    if (out_free) begin
                        fsum_reg      <= '0;
                        ssum_reg      <= '0;
                        count_reg     <= '0;
                        tail_reg      <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) x_reg <= s_z_sample;

        if (cw.op == OP_PREP && !first) begin
            med_reg <= med3(win0_reg, win1_reg, x_reg);
        end else if (cw.op == OP_SUMS && last && !tail_reg) begin
            // last sample is its own right neighbor
            med_reg <= med3(win0_reg, win1_reg, win1_reg);
        end

        if (cw.op == OP_DIFF) absd_reg <= diff_abs[ABSD_W-1:0];

        unique case (cw.mul_dst)
            MD_Q:    q_reg <= product[Q_W-1:0];
            MD_P:    p_reg <= product[P_W-1:0];
            MD_R:    r_reg <= product;
            default: begin
            end
        endcase

        if (cw.op == OP_DIV_MUL) begin
            fq_reg <= fdiv_prod[RCP_SH +: DIGIT_W];
            sq_reg <= sdiv_prod[RCP_SH +: DIGIT_W];
        end

        if (cw.op == OP_DIV_INIT) begin
            frem_reg <= '0;
            srem_reg <= '0;
        end else if (cw.op == OP_DIV_STEP) begin
            frem_reg <= REM_W'(fdiv_t - fdiv_back);
            srem_reg <= REM_W'(sdiv_t - sdiv_back);
        end

        if (cw.op == OP_EMIT && out_free) begin
            m_speech_detected  <= flag;
            m_speech_level     <= fsum_reg[LEVEL_W-1:0];
            m_background_level <= ssum_reg[LEVEL_W-1:0];
        end
    end

    assign m_valid = out_valid_reg;

endmodule
`default_nettype wire

/* sim/accel_speech_energy_detector_top_tb.sv */
// ----------------------------------------------------------------------------
// accel_speech_energy_detector_top_tb
// Self-checking bench for the z-axis speech energy detector. Samples are sent
// in whole blocks under a series of register settings. These include the
// reset values, the weight and ratio extremes, zero weights and random values.
// A tracker class predicts each block result from the accepted samples, and
// the returned words are compared field by field in order. Both handshakes
// stall at random, except for one stretch of steady traffic.
// ----------------------------------------------------------------------------
module accel_speech_energy_detector_top_tb;
    import ased_pkg::*;

    localparam int BLOCK       = 64;
    localparam int N_SETTINGS  = 10;
    localparam int IDLE_PCT    = 27;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED  = 22;
    localparam int MAX_REPORTS = 10;

    // index 3 is unmapped, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] zval_t;

    typedef struct packed {
        logic               detected;
        logic [LEVEL_W-1:0] speech;
        logic [LEVEL_W-1:0] background;
    } levels_t;

    typedef enum int {
        SHAPE_NOISE,
        SHAPE_QUIET,
        SHAPE_FLAT,
        SHAPE_BURST,
        SHAPE_SPIKES
    } shape_t;

    class level_tracker;
        logic [ALPHA_W-1:0] sa    = SPEECH_ALPHA_RST;
        logic [ALPHA_W-1:0] ba    = BACKGROUND_ALPHA_RST;
        logic [RATIO_W-1:0] ratio = THRESHOLD_RATIO_RST;

        zval_t              win_old     = '0;
        zval_t              win_new     = '0;
        zval_t              last_median = '0;
        int unsigned        pos         = 0;
        logic [LEVEL_W-1:0] fast_e      = '0;
        logic [LEVEL_W-1:0] slow_e      = '0;
        logic [SUM_W-1:0]   fast_sum    = '0;
        logic [SUM_W-1:0]   slow_sum    = '0;

        levels_t     level_queue[$];
        int unsigned mismatches   = 0;
        int unsigned results_seen = 0;
        int unsigned flagged      = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SPEECH_ALPHA:     sa = data[ALPHA_W-1:0];
                CFG_BACKGROUND_ALPHA: ba = data[ALPHA_W-1:0];
                CFG_THRESHOLD_RATIO:  ratio = data[RATIO_W-1:0];
                default: ;
            endcase
        endfunction

        // median as max(min(a,b), min(max(a,b),c))
        function zval_t middle(zval_t a, zval_t b, zval_t c);
            zval_t lo;
            zval_t hi;
            zval_t cap;
            lo  = (a < b) ? a : b;
            hi  = (a < b) ? b : a;
            cap = (hi < c) ? hi : c;
            return (lo > cap) ? lo : cap;
        endfunction

        function logic [LEVEL_W-1:0] smooth(logic [LEVEL_W-1:0] e, logic [63:0] q,
                                            logic [ALPHA_W-1:0] a);
            logic [63:0] acc;
            acc = {48'd0, a} * (q << 16) + (64'd65536 - {48'd0, a}) * {22'd0, e}
                + 64'd32768;
            return acc[LEVEL_W+15:16];
        endfunction

        function logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] s, logic [LEVEL_W-1:0] v);
            logic [SUM_W:0] t;
            t = {1'b0, s} + {7'd0, v};
            return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
        endfunction

        function void fold(zval_t m);
            logic signed [SAMPLE_W+1:0] d;
            logic [SAMPLE_W:0]          mag;
            logic [63:0]                q;
            d   = m - last_median;
            mag = d[SAMPLE_W+1] ? -d : d;
            q   = mag * mag;
            last_median = m;
            fast_e   = smooth(fast_e, q, sa);
            slow_e   = smooth(slow_e, q, ba);
            fast_sum = add_sat(fast_sum, fast_e);
            slow_sum = add_sat(slow_sum, slow_e);
        endfunction

        function void take_sample(zval_t x);
            logic [LEVEL_W-1:0] sm;
            logic [LEVEL_W-1:0] bm;
            levels_t            r;
            if (pos == 0) begin
                win_old = x;
                win_new = x;
            end else begin
                fold(middle(win_old, win_new, x));
                win_old = win_new;
                win_new = x;
            end
            if (pos + 1 < BLOCK) begin
                pos++;
                return;
            end
            // last sample is its own right neighbor
            fold(middle(win_old, win_new, win_new));
            sm = LEVEL_W'(fast_sum / SUM_W'(BLOCK));
            bm = LEVEL_W'(slow_sum / SUM_W'(BLOCK));
            r.detected   = {22'd0, sm} > {60'd0, ratio} * {22'd0, bm};
            r.speech     = sm;
            r.background = bm;
            level_queue.push_back(r);
            fast_sum = '0;
            slow_sum = '0;
            pos      = 0;
        endfunction

        function void check_levels(levels_t got);
            levels_t want;
            results_seen++;
            if (level_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected result word flag=%0b speech=%0d bg=%0d",
                             got.detected, got.speech, got.background);
                return;
            end
            want = level_queue.pop_front();
            if (got.detected)
                flagged++;
            if (got.detected !== want.detected || got.speech !== want.speech ||
                got.background !== want.background) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: result %0d mismatch", results_seen);
                    $display("  flag   exp %0b got %0b", want.detected, got.detected);
                    $display("  speech exp %0d got %0d", want.speech, got.speech);
                    $display("  bg     exp %0d got %0d", want.background, got.background);
                end
            end
        endfunction

        function int pending();
            return level_queue.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    zval_t                 s_z_sample = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_speech_detected;
    logic [LEVEL_W-1:0]    m_speech_level;
    logic [LEVEL_W-1:0]    m_background_level;

    level_tracker trk;
    bit           steady  = 1'b0;
    int           cycles  = 0;
    int           sent    = 0;
    int           nblocks = 0;

    int directed_z[N_DIRECTED] = '{-4096, 4095, -4096, 4095, 0, -1, 1, 4095, 4095,
                                   -4096, -4096, 0, 0, 0, 2047, -2048, 0, 4095, 0,
                                   0, -4096, 0};

    accel_speech_energy_detector_top #(
        .BLOCK_LEN(BLOCK)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_z_sample        (s_z_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_speech_detected (m_speech_detected),
        .m_speech_level    (m_speech_level),
        .m_background_level(m_background_level)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending", cycles, trk.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: check on handshake, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            trk.check_levels({m_speech_detected, m_speech_level, m_background_level});
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        trk.write_reg(idx, data);
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [ALPHA_W-1:0] sa, input logic [ALPHA_W-1:0] ba,
                                 input logic [RATIO_W-1:0] ratio);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        cfg_write(CFG_SPEECH_ALPHA, sa);
        cfg_write(CFG_BACKGROUND_ALPHA, ba);
        // upper bits of the ratio word must be ignored
        cfg_write(CFG_THRESHOLD_RATIO, {junk[CFG_DATA_W-1:RATIO_W], ratio});
        cfg_write(CFG_UNUSED, ~junk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_sample(input zval_t v);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_z_sample <= v;
        do @(posedge aclk); while (!s_ready);
        trk.take_sample(v);
        sent++;
    endtask

    // called right after an accepted word, so valid drops with a single assignment
    task automatic drain;
        s_valid <= 1'b0;
        while (trk.pending() != 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    function automatic zval_t shaped(shape_t shp, int idx, zval_t bias);
        zval_t jitter;
        jitter = zval_t'(int'($urandom_range(8)) - 4);
        case (shp)
            SHAPE_QUIET:  return bias + jitter;
            SHAPE_FLAT:   return bias;
            SHAPE_BURST:  return (idx >= 20 && idx < 40) ? zval_t'($urandom) : bias + jitter;
            // isolated spikes, mostly removed by the median
            SHAPE_SPIKES: return (idx % 7 == 3) ? ($urandom_range(1) ? zval_t'(4095)
                                                                      : zval_t'(-4096))
                                                : bias;
            default:      return zval_t'($urandom);
        endcase
    endfunction

    initial begin
        logic [ALPHA_W-1:0] sa_set[N_SETTINGS];
        logic [ALPHA_W-1:0] ba_set[N_SETTINGS];
        logic [RATIO_W-1:0] ratio_set[N_SETTINGS];
        shape_t             shp;
        zval_t              bias;
        zval_t              v;
        int                 blocks_here;

        trk = new;
        sa_set    = '{SPEECH_ALPHA_RST, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'd1311,
                      16'd0, 16'd0, 16'd0, 16'd0};
        ba_set    = '{BACKGROUND_ALPHA_RST, 16'hFFFF, 16'd1, 16'd0, 16'd1, 16'd66,
                      16'd0, 16'd0, 16'd0, 16'd0};
        ratio_set = '{THRESHOLD_RATIO_RST, 4'd15, 4'd1, 4'd0, 4'd15, 4'd2,
                      4'd0, 4'd0, 4'd0, 4'd0};
        for (int k = 6; k < N_SETTINGS; k++) begin
            sa_set[k]    = ALPHA_W'($urandom);
            ba_set[k]    = ALPHA_W'($urandom_range(4000));
            ratio_set[k] = RATIO_W'($urandom);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        for (int ph = 0; ph < N_SETTINGS; ph++) begin
            // the first setting runs on reset values
            if (ph > 0) begin
                drain();
                apply_setting(sa_set[ph], ba_set[ph], ratio_set[ph]);
            end
            steady      = (ph == 5);
            blocks_here = (ph == 0) ? 2 : 3;
            for (int b = 0; b < blocks_here; b++) begin
                shp  = shape_t'($urandom_range(SHAPE_SPIKES));
                bias = zval_t'(int'($urandom_range(4000)) - 2000);
                for (int i = 0; i < BLOCK; i++) begin
                    if (ph == 0 && b == 0 && i < N_DIRECTED)
                        v = zval_t'(directed_z[i]);
                    else
                        v = shaped(shp, i, bias);
                    send_sample(v);
                end
                nblocks++;
            end
        end
        steady = 1'b0;
        drain();
        repeat (70) @(posedge aclk);

        $display("Sent %0d samples in %0d blocks over %0d register settings.",
                 sent, nblocks, N_SETTINGS);
        $display("Checked %0d block results, %0d flagged as speech, %0d mismatches.",
                 trk.results_seen, trk.flagged, trk.mismatches);
        if (trk.mismatches == 0 && trk.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
